// ----- sv/dnrs_pkg.sv -----
// Shared types and constants for the directional nearest rectangle selector.
// Used by every module of the block; depends on nothing.

package dnrs_pkg;

    localparam int ID_BITS     = 8;
    localparam int COORD_BITS  = 13;
    localparam int SIZE_BITS   = 12;
    localparam int SCORE_BITS  = 17;

    // Doubled centre (2*x + w) and its difference against the source.
    localparam int CTR2_BITS   = COORD_BITS + 2;
    localparam int DELTA_BITS  = CTR2_BITS + 1;
    localparam int MAG_BITS    = DELTA_BITS - 1;
    localparam int EDGE_BITS   = COORD_BITS + 1;

    localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};

    typedef logic [ID_BITS-1:0]    id_t;
    typedef logic [SCORE_BITS-1:0] score_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    typedef enum logic {
        FUNC_START     = 1'b0,
        FUNC_CANDIDATE = 1'b1
    } func_t;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic   is_start;
        logic   hit;
        logic   last;
        id_t    id;
        score_t score;
    } q_item_t;

endpackage

// ----- sv/directional_nearest_rect_select_unit.sv -----
// Top level of the directional nearest rectangle selector.
// Depends on dnrs_pkg, dnrs_front, dnrs_queue and dnrs_back.
//
//   Channel   Handshake                   Payload
//   item      item_valid / item_stall     func, rect_x, rect_y, rect_width,
//                                         rect_height, item_id, direction, is_last
//   result    result_valid / result_stall found, best_id, best_score
//
// One item is taken per cycle while the queue is not full; it is scored in the cycle it is
// accepted and reaches the running-best compare through a two-entry queue.
// A result is valid once its last item has left the queue and been written to the output register.
// Reset clears the source to a zero rectangle facing up and empties the running best.
// A stalled result holds the output register; items keep flowing until the queue fills.

module directional_nearest_rect_select_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic                                   func,
    input  logic signed [dnrs_pkg::COORD_BITS-1:0] rect_x,
    input  logic signed [dnrs_pkg::COORD_BITS-1:0] rect_y,
    input  logic [dnrs_pkg::SIZE_BITS-1:0]         rect_width,
    input  logic [dnrs_pkg::SIZE_BITS-1:0]         rect_height,
    input  dnrs_pkg::id_t                          item_id,
    input  logic [1:0]                             direction,
    input  logic                                   is_last,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic                                   found,
    output dnrs_pkg::id_t                          best_id,
    output dnrs_pkg::score_t                       best_score
);

    logic              accept, pop, q_empty, q_full;
    dnrs_pkg::q_item_t classified, head;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    dnrs_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .func        (func),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .item_id     (item_id),
        .direction   (direction),
        .is_last     (is_last),
        .classified  (classified)
    );

    dnrs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (classified),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    dnrs_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (q_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .best_id      (best_id),
        .best_score   (best_score)
    );

endmodule

// ----- sv/dnrs_front.sv -----
// Front end: holds the source rectangle and scores each candidate against it.
// Depends on dnrs_pkg for field widths, the direction codes and the item struct.

module dnrs_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic                                func,
    input  logic signed [dnrs_pkg::COORD_BITS-1:0] rect_x,
    input  logic signed [dnrs_pkg::COORD_BITS-1:0] rect_y,
    input  logic [dnrs_pkg::SIZE_BITS-1:0]      rect_width,
    input  logic [dnrs_pkg::SIZE_BITS-1:0]      rect_height,
    input  dnrs_pkg::id_t                       item_id,
    input  logic [1:0]                          direction,
    input  logic                                is_last,
    output dnrs_pkg::q_item_t                   classified
);

    localparam int CB = dnrs_pkg::CTR2_BITS;
    localparam int DB = dnrs_pkg::DELTA_BITS;
    localparam int MB = dnrs_pkg::MAG_BITS;
    localparam int EB = dnrs_pkg::EDGE_BITS;
    localparam int SB = dnrs_pkg::SCORE_BITS;

    logic signed [CB-1:0] src_cx2_reg, src_cx2_next;
    logic signed [CB-1:0] src_cy2_reg, src_cy2_next;
    logic signed [EB-1:0] src_left_reg, src_left_next;
    logic signed [EB-1:0] src_top_reg, src_top_next;
    logic signed [EB-1:0] src_right_reg, src_right_next;
    logic signed [EB-1:0] src_bottom_reg, src_bottom_next;
    logic                 src_w_nz_reg, src_w_nz_next;
    logic                 src_h_nz_reg, src_h_nz_next;
    dnrs_pkg::id_t        src_id_reg, src_id_next;
    dnrs_pkg::dir_t       dir_reg, dir_next;

    logic signed [CB-1:0] cx2, cy2;
    logic signed [EB-1:0] left, top, right, bottom;
    logic signed [DB-1:0] dx2, dy2;
    logic [MB-1:0]        mag_x, mag_y, main_d, cross_d;
    logic                 beyond, overlap, vertical;
    logic [SB:0]          sum;
    dnrs_pkg::score_t     score;

    always_comb
    begin
        cx2 = $signed({rect_x[dnrs_pkg::COORD_BITS-1], rect_x, 1'b0})
            + $signed({3'b000, rect_width});
        cy2 = $signed({rect_y[dnrs_pkg::COORD_BITS-1], rect_y, 1'b0})
            + $signed({3'b000, rect_height});
        left   = $signed({rect_x[dnrs_pkg::COORD_BITS-1], rect_x});
        top    = $signed({rect_y[dnrs_pkg::COORD_BITS-1], rect_y});
        right  = left + $signed({2'b00, rect_width});
        bottom = top + $signed({2'b00, rect_height});

        dx2 = $signed({cx2[CB-1], cx2}) - $signed({src_cx2_reg[CB-1], src_cx2_reg});
        dy2 = $signed({cy2[CB-1], cy2}) - $signed({src_cy2_reg[CB-1], src_cy2_reg});
        mag_x = dx2[DB-1] ? MB'(-dx2) : dx2[MB-1:0];
        mag_y = dy2[DB-1] ? MB'(-dy2) : dy2[MB-1:0];

        vertical = (dir_reg == dnrs_pkg::DIR_UP) || (dir_reg == dnrs_pkg::DIR_DOWN);

        unique case (dir_reg)
            dnrs_pkg::DIR_UP:    beyond = dy2[DB-1];
            dnrs_pkg::DIR_DOWN:  beyond = !dy2[DB-1] && (dy2 != '0);
            dnrs_pkg::DIR_LEFT:  beyond = dx2[DB-1];
            dnrs_pkg::DIR_RIGHT: beyond = !dx2[DB-1] && (dx2 != '0);
            default:             beyond = 1'b0;
        endcase

        // Overlap on the cross axis needs both extents non-empty.
        if (vertical)
        begin
            main_d  = mag_y;
            cross_d = mag_x;
            overlap = (src_right_reg > left) && (right > src_left_reg)
                   && src_w_nz_reg && (rect_width != '0);
        end
        else
        begin
            main_d  = mag_x;
            cross_d = mag_y;
            overlap = (src_bottom_reg > top) && (bottom > src_top_reg)
                   && src_h_nz_reg && (rect_height != '0);
        end

        sum = {(SB + 1 - MB)'(0), main_d} + {(SB - MB)'(0), cross_d, 1'b0}
            + {(SB + 1 - MB)'(0), cross_d};
        score = sum[SB] ? dnrs_pkg::SCORE_MAX : sum[SB-1:0];

        classified.is_start = (func == dnrs_pkg::FUNC_START);
        classified.hit      = (func == dnrs_pkg::FUNC_CANDIDATE)
                           && (item_id != src_id_reg) && beyond && overlap;
        classified.last     = is_last;
        classified.id       = item_id;
        classified.score    = score;
    end

    always_comb
    begin
        src_cx2_next    = src_cx2_reg;
        src_cy2_next    = src_cy2_reg;
        src_left_next   = src_left_reg;
        src_top_next    = src_top_reg;
        src_right_next  = src_right_reg;
        src_bottom_next = src_bottom_reg;
        src_w_nz_next   = src_w_nz_reg;
        src_h_nz_next   = src_h_nz_reg;
        src_id_next     = src_id_reg;
        dir_next        = dir_reg;
        if (accept && (func == dnrs_pkg::FUNC_START))
        begin
            src_cx2_next    = cx2;
            src_cy2_next    = cy2;
            src_left_next   = left;
            src_top_next    = top;
            src_right_next  = right;
            src_bottom_next = bottom;
            src_w_nz_next   = (rect_width != '0);
            src_h_nz_next   = (rect_height != '0);
            src_id_next     = item_id;
            dir_next        = dnrs_pkg::dir_t'(direction);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_cx2_reg    <= '0;
            src_cy2_reg    <= '0;
            src_left_reg   <= '0;
            src_top_reg    <= '0;
            src_right_reg  <= '0;
            src_bottom_reg <= '0;
            src_w_nz_reg   <= 1'b0;
            src_h_nz_reg   <= 1'b0;
            src_id_reg     <= '0;
            dir_reg        <= dnrs_pkg::DIR_UP;
        end
        else
        begin
            src_cx2_reg    <= src_cx2_next;
            src_cy2_reg    <= src_cy2_next;
            src_left_reg   <= src_left_next;
            src_top_reg    <= src_top_next;
            src_right_reg  <= src_right_next;
            src_bottom_reg <= src_bottom_next;
            src_w_nz_reg   <= src_w_nz_next;
            src_h_nz_reg   <= src_h_nz_next;
            src_id_reg     <= src_id_next;
            dir_reg        <= dir_next;
        end
    end

endmodule

// ----- sv/dnrs_queue.sv -----
// Two-entry queue of classified items between the front and the back end.
// Depends on dnrs_pkg for the item struct.

module dnrs_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dnrs_pkg::q_item_t push_item,
    input  logic              pop,
    output dnrs_pkg::q_item_t head,
    output logic              empty,
    output logic              full
);

    dnrs_pkg::q_item_t entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    always_comb
    begin
        empty       = (count_reg == 2'd0);
        full        = (count_reg == 2'd2);
        head        = entry_reg[rd_ptr_reg];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/dnrs_back.sv -----
// Back end: keeps the running best candidate and issues the result on the last item.
// Depends on dnrs_pkg for the item struct and the score limit.

module dnrs_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  dnrs_pkg::q_item_t head,
    input  logic              empty,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              found,
    output dnrs_pkg::id_t     best_id,
    output dnrs_pkg::score_t  best_score
);

    logic             any_reg, any_next;
    dnrs_pkg::id_t    best_id_reg, best_id_next;
    dnrs_pkg::score_t best_score_reg, best_score_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg, out_found_next;
    dnrs_pkg::id_t    out_id_reg, out_id_next;
    dnrs_pkg::score_t out_score_reg, out_score_next;

    logic             base_any, upd_any, take, slot_free;
    dnrs_pkg::id_t    base_id, upd_id;
    dnrs_pkg::score_t base_score, upd_score;

    always_comb
    begin
        slot_free = !out_valid_reg || !result_stall;
        // A last item needs the output slot; anything else drains freely.
        pop = !empty && (!head.last || slot_free);

        // A start item clears the running best before anything else.
        base_any   = head.is_start ? 1'b0 : any_reg;
        base_id    = head.is_start ? '0 : best_id_reg;
        base_score = head.is_start ? dnrs_pkg::SCORE_MAX : best_score_reg;

        take      = head.hit && (head.score < base_score);
        upd_any   = take ? 1'b1 : base_any;
        upd_id    = take ? head.id : base_id;
        upd_score = take ? head.score : base_score;

        any_next        = any_reg;
        best_id_next    = best_id_reg;
        best_score_next = best_score_reg;
        out_found_next  = out_found_reg;
        out_id_next     = out_id_reg;
        out_score_next  = out_score_reg;
        out_valid_next  = out_valid_reg && result_stall;

        if (pop)
        begin
            if (head.last)
            begin
                out_valid_next  = 1'b1;
                out_found_next  = upd_any;
                out_id_next     = upd_any ? upd_id : '0;
                out_score_next  = upd_any ? upd_score : '0;
                any_next        = 1'b0;
                best_id_next    = '0;
                best_score_next = dnrs_pkg::SCORE_MAX;
            end
            else
            begin
                any_next        = upd_any;
                best_id_next    = upd_id;
                best_score_next = upd_score;
            end
        end

        result_valid = out_valid_reg;
        found        = out_found_reg;
        best_id      = out_id_reg;
        best_score   = out_score_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg        <= 1'b0;
            best_id_reg    <= '0;
            best_score_reg <= dnrs_pkg::SCORE_MAX;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            any_reg        <= any_next;
            best_id_reg    <= best_id_next;
            best_score_reg <= best_score_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        out_id_reg    <= out_id_next;
        out_score_reg <= out_score_next;
    end

endmodule

// ----- sim/tb_directional_nearest_rect_select_unit.sv -----
// Self-checking testbench for directional_nearest_rect_select_unit.
// Depends on dnrs_pkg and the block's RTL; predicts each query result and compares it
// with what the block returns, under random idling on both channels.

module tb_directional_nearest_rect_select_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        dnrs_pkg::func_t                        fn;
        logic signed [dnrs_pkg::COORD_BITS-1:0] x;
        logic signed [dnrs_pkg::COORD_BITS-1:0] y;
        logic [dnrs_pkg::SIZE_BITS-1:0]         w;
        logic [dnrs_pkg::SIZE_BITS-1:0]         h;
        dnrs_pkg::id_t                          id;
        dnrs_pkg::dir_t                         dir;
        logic                                   last;
    } rect_item_t;

    typedef struct {
        logic             found;
        dnrs_pkg::id_t    id;
        dnrs_pkg::score_t score;
    } pick_t;

    // Tracks the source rectangle and the running best, and holds the picks still due.
    class focus_tracker;
        int             src_x;
        int             src_y;
        int             src_w;
        int             src_h;
        dnrs_pkg::id_t  src_id;
        dnrs_pkg::dir_t src_dir;
        dnrs_pkg::id_t  lead_id;
        int             lead_score;
        logic           lead_valid;
        pick_t          expected_picks[$];
        int             mismatches;
        int             items_seen;
        int             picks_checked;
        int             picks_found;

        function new();
            src_x = 0;
            src_y = 0;
            src_w = 0;
            src_h = 0;
            src_id = '0;
            src_dir = dnrs_pkg::DIR_UP;
            clear_lead();
            mismatches = 0;
            items_seen = 0;
            picks_checked = 0;
            picks_found = 0;
        endfunction

        function void clear_lead();
            lead_id = '0;
            lead_score = int'(dnrs_pkg::SCORE_MAX);
            lead_valid = 1'b0;
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction

        // Score in half-pixel units, or -1 when the candidate does not qualify.
        function int rate_candidate(int x, int y, int w, int h);
            int dx2;
            int dy2;
            int along;
            int across;
            int overlap;
            int s;
            dx2 = (2 * x + w) - (2 * src_x + src_w);
            dy2 = (2 * y + h) - (2 * src_y + src_h);
            unique case (src_dir)
                dnrs_pkg::DIR_UP:    if (dy2 > -1) return -1;
                dnrs_pkg::DIR_DOWN:  if (dy2 < 1) return -1;
                dnrs_pkg::DIR_LEFT:  if (dx2 > -1) return -1;
                default:             if (dx2 < 1) return -1;
            endcase
            if (src_dir == dnrs_pkg::DIR_UP || src_dir == dnrs_pkg::DIR_DOWN)
            begin
                along = (dy2 < 0) ? -dy2 : dy2;
                across = (dx2 < 0) ? -dx2 : dx2;
                overlap = ((src_x + src_w < x + w) ? src_x + src_w : x + w)
                        - ((src_x > x) ? src_x : x);
            end
            else
            begin
                along = (dx2 < 0) ? -dx2 : dx2;
                across = (dy2 < 0) ? -dy2 : dy2;
                overlap = ((src_y + src_h < y + h) ? src_y + src_h : y + h)
                        - ((src_y > y) ? src_y : y);
            end
            if (overlap <= 0)
                return -1;
            s = along + 3 * across;
            if (s > int'(dnrs_pkg::SCORE_MAX))
                s = int'(dnrs_pkg::SCORE_MAX);
            return s;
        endfunction

        function void take_item(rect_item_t it);
            int    s;
            pick_t p;
            items_seen++;
            if (it.fn == dnrs_pkg::FUNC_START)
            begin
                src_x = int'(it.x);
                src_y = int'(it.y);
                src_w = int'(it.w);
                src_h = int'(it.h);
                src_id = it.id;
                src_dir = it.dir;
                clear_lead();
            end
            else if (it.id != src_id)
            begin
                s = rate_candidate(int'(it.x), int'(it.y), int'(it.w), int'(it.h));
                if (s >= 0 && s < lead_score)
                begin
                    lead_score = s;
                    lead_id = it.id;
                    lead_valid = 1'b1;
                end
            end
            if (it.last)
            begin
                p.found = lead_valid;
                p.id = lead_valid ? lead_id : '0;
                p.score = lead_valid ? dnrs_pkg::score_t'(lead_score) : '0;
                expected_picks = {expected_picks, p};
                clear_lead();
            end
        endfunction

        task report_mismatch(string what);
            $display("%0t ns mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_pick(logic f, dnrs_pkg::id_t id, dnrs_pkg::score_t sc);
            pick_t p;
            if (expected_picks.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result found=%0b id=%0d score=%0d",
                                          f, id, sc));
                return;
            end
            p = expected_picks.pop_front();
            picks_checked++;
            if (p.found)
                picks_found++;
            if (f !== p.found)
                report_mismatch($sformatf("found %0b, expected %0b", f, p.found));
            if (id !== p.id)
                report_mismatch($sformatf("best_id %0d, expected %0d", id, p.id));
            if (sc !== p.score)
                report_mismatch($sformatf("best_score %0d, expected %0d", sc, p.score));
        endtask
    endclass

    logic                                   clk = 1'b0;
    logic                                   rst_n;
    logic                                   item_valid;
    logic                                   item_stall;
    logic                                   func;
    logic signed [dnrs_pkg::COORD_BITS-1:0] rect_x;
    logic signed [dnrs_pkg::COORD_BITS-1:0] rect_y;
    logic [dnrs_pkg::SIZE_BITS-1:0]         rect_width;
    logic [dnrs_pkg::SIZE_BITS-1:0]         rect_height;
    dnrs_pkg::id_t                          item_id;
    logic [1:0]                             direction;
    logic                                   is_last;
    logic                                   result_valid;
    logic                                   result_stall;
    logic                                   found;
    dnrs_pkg::id_t                          best_id;
    dnrs_pkg::score_t                       best_score;

    focus_tracker sb;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_left;
    logic         burst;
    rect_item_t   src_shape;

    directional_nearest_rect_select_unit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .func(func),
        .rect_x(rect_x),
        .rect_y(rect_y),
        .rect_width(rect_width),
        .rect_height(rect_height),
        .item_id(item_id),
        .direction(direction),
        .is_last(is_last),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .found(found),
        .best_id(best_id),
        .best_score(best_score)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Run did not complete in time.");
        $display("== FAIL ==");
        $finish;
    end

    // Result side: check what was taken at this edge, then choose the next stall.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
            sb.check_pick(found, best_id, best_score);
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    task automatic send_item(rect_item_t it);
        item_valid <= 1'b1;
        func <= it.fn;
        rect_x <= it.x;
        rect_y <= it.y;
        rect_width <= it.w;
        rect_height <= it.h;
        item_id <= it.id;
        direction <= it.dir;
        is_last <= it.last;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        sb.take_item(it);
        if (it.fn == dnrs_pkg::FUNC_START)
            src_shape = it;
        while (!burst && $urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic put(dnrs_pkg::func_t fn, int x, int y, int w, int h, int id,
                       dnrs_pkg::dir_t dir, bit last);
        rect_item_t it;
        it.fn = fn;
        it.x = dnrs_pkg::COORD_BITS'(x);
        it.y = dnrs_pkg::COORD_BITS'(y);
        it.w = dnrs_pkg::SIZE_BITS'(w);
        it.h = dnrs_pkg::SIZE_BITS'(h);
        it.id = dnrs_pkg::id_t'(id);
        it.dir = dir;
        it.last = last;
        send_item(it);
    endtask

    task automatic wait_for_picks();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic rect_item_t any_item();
        rect_item_t it;
        it.fn = dnrs_pkg::func_t'($urandom_range(0, 1));
        it.x = dnrs_pkg::COORD_BITS'($urandom_range(0, 8191));
        it.y = dnrs_pkg::COORD_BITS'($urandom_range(0, 8191));
        it.w = dnrs_pkg::SIZE_BITS'($urandom_range(0, 4095));
        it.h = dnrs_pkg::SIZE_BITS'($urandom_range(0, 4095));
        it.id = dnrs_pkg::id_t'($urandom_range(0, 255));
        it.dir = dnrs_pkg::dir_t'($urandom_range(0, 3));
        it.last = ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    function automatic logic signed [dnrs_pkg::COORD_BITS-1:0] clamp_coord(int v);
        if (v < -4096)
            return dnrs_pkg::COORD_BITS'(-4096);
        if (v > 4095)
            return dnrs_pkg::COORD_BITS'(4095);
        return dnrs_pkg::COORD_BITS'(v);
    endfunction

    function automatic logic [dnrs_pkg::SIZE_BITS-1:0] pick_size();
        if ($urandom_range(0, 11) == 0)
            return '0;
        return dnrs_pkg::SIZE_BITS'($urandom_range(1, 400));
    endfunction

    function automatic rect_item_t random_source();
        rect_item_t it;
        it = any_item();
        it.fn = dnrs_pkg::FUNC_START;
        it.last = ($urandom_range(0, 15) == 0);
        // Mostly modest sources so that nearby candidates often qualify.
        if ($urandom_range(0, 3) != 0)
        begin
            it.x = dnrs_pkg::COORD_BITS'(int'($urandom_range(0, 6000)) - 3000);
            it.y = dnrs_pkg::COORD_BITS'(int'($urandom_range(0, 6000)) - 3000);
            it.w = pick_size();
            it.h = pick_size();
        end
        return it;
    endfunction

    function automatic rect_item_t near_candidate(rect_item_t s);
        rect_item_t c;
        int         span;
        c = any_item();
        c.fn = dnrs_pkg::FUNC_CANDIDATE;
        if ($urandom_range(0, 9) != 0)
        begin
            span = int'(s.w) + int'(s.h) + 200;
            c.x = clamp_coord(int'(s.x) + int'($urandom_range(0, 2 * span)) - span);
            c.y = clamp_coord(int'(s.y) + int'($urandom_range(0, 2 * span)) - span);
            c.w = pick_size();
            c.h = pick_size();
        end
        if ($urandom_range(0, 7) == 0)
            c.id = s.id;
        return c;
    endfunction

    // A well-formed query, now and then without its start item so that it reuses the source.
    task automatic run_query();
        rect_item_t it;
        int         n;
        if ($urandom_range(0, 9) != 0)
        begin
            it = random_source();
            send_item(it);
            if (it.last)
                return;
        end
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
        begin
            it = near_candidate(src_shape);
            it.last = (k == n - 1);
            send_item(it);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        func <= dnrs_pkg::FUNC_START;
        rect_x <= '0;
        rect_y <= '0;
        rect_width <= '0;
        rect_height <= '0;
        item_id <= '0;
        direction <= dnrs_pkg::DIR_UP;
        is_last <= 1'b0;
        result_stall <= 1'b0;
        send_idle_pct = 34;
        recv_stall_pct = 58;
        hold_left = 0;
        burst = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A candidate straight after reset meets the empty source and cannot qualify.
        put(dnrs_pkg::FUNC_CANDIDATE, -5, -20, 10, 10, 5, dnrs_pkg::DIR_UP, 1);
        put(dnrs_pkg::FUNC_START, 0, 0, 100, 100, 7, dnrs_pkg::DIR_UP, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, 10, -200, 50, 50, 1, dnrs_pkg::DIR_DOWN, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, 0, -60, 100, 100, 7, dnrs_pkg::DIR_UP, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, 40, -200, 50, 50, 2, dnrs_pkg::DIR_UP, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, 0, 300, 100, 100, 3, dnrs_pkg::DIR_UP, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, 0, -150, 0, 50, 4, dnrs_pkg::DIR_UP, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, 200, -150, 50, 50, 6, dnrs_pkg::DIR_UP, 1);
        // Same source again: half a pixel ahead qualifies, level centres do not.
        put(dnrs_pkg::FUNC_CANDIDATE, 0, 0, 100, 99, 9, dnrs_pkg::DIR_UP, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, 0, 0, 100, 100, 10, dnrs_pkg::DIR_UP, 1);
        put(dnrs_pkg::FUNC_START, -4096, -4096, 4095, 4095, 0, dnrs_pkg::DIR_RIGHT, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, 4095, -4096, 4095, 4095, 255, dnrs_pkg::DIR_LEFT, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, -4096, 4095, 4095, 4095, 128, dnrs_pkg::DIR_UP, 1);
        put(dnrs_pkg::FUNC_START, 4095, 4095, 4095, 4095, 255, dnrs_pkg::DIR_DOWN, 1);
        put(dnrs_pkg::FUNC_START, 0, 0, 1, 1, 200, dnrs_pkg::DIR_LEFT, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, -1, 0, 2, 1, 201, dnrs_pkg::DIR_UP, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, -1, 0, 1, 1, 202, dnrs_pkg::DIR_UP, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, -4096, -4096, 4095, 4095, 203, dnrs_pkg::DIR_UP, 1);
        put(dnrs_pkg::FUNC_START, 100, -50, 0, 0, 12, dnrs_pkg::DIR_DOWN, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, 90, 100, 20, 20, 13, dnrs_pkg::DIR_DOWN, 1);
        put(dnrs_pkg::FUNC_START, -100, -100, 200, 200, 50, dnrs_pkg::DIR_UP, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, -4096, -4096, 4095, 4095, 51, dnrs_pkg::DIR_RIGHT, 0);
        put(dnrs_pkg::FUNC_CANDIDATE, -100, -300, 200, 100, 52, dnrs_pkg::DIR_UP, 1);
        wait_for_picks();

        // The receiver holds off while items keep coming, so the block backs up.
        hold_left = 120;
        burst = 1'b1;
        repeat (15) run_query();
        burst = 1'b0;
        wait_for_picks();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 58 : 0;
            recv_stall_pct = (phase == 0) ? 58 : (phase == 1) ? 34 : 0;
            while (sb.items_seen < 160 + 135 * phase)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_item(any_item());
                else
                    run_query();
            end
            wait_for_picks();
        end

        $display("Covered %0d items and %0d query results, %0d of them with a rectangle picked.",
                 sb.items_seen, sb.picks_checked, sb.picks_found);
        $display("Idling ran both ways round and not at all, with one long result hold-off.");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/dnrs_pkg.sv
sv/dnrs_front.sv
sv/dnrs_queue.sv
sv/dnrs_back.sv
sv/directional_nearest_rect_select_unit.sv
sim/tb_directional_nearest_rect_select_unit.sv
